FILE: rtl/array_region_offset_folder_macros.svh
// Assertion macros used by the checker file.
`ifndef ARRAY_REGION_OFFSET_FOLDER_MACROS_SVH
`define ARRAY_REGION_OFFSET_FOLDER_MACROS_SVH

// Clocked assertion, off while reset is high.
`define AROF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define AROF_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/arof_pkg.sv
// ----------------------------------------------------------------------------
// arof_pkg
// Shared codes, widths and the sequencer state type of the region folder.
// ----------------------------------------------------------------------------
package arof_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int SLOT_WIDTH  = 3;
   localparam int CFG_WIDTH   = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register slot (paddr bit 2) of entries_in_use
   localparam logic CSR_ENTRIES_SLOT = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } arof_state_type;

endpackage

FILE: rtl/arof_if.sv
// ----------------------------------------------------------------------------
// arof_if
// Valid/ready channels for requests and responses of the region folder.
// ----------------------------------------------------------------------------
interface arof_req_if import arof_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [SLOT_WIDTH-1:0]  entry_index;
   logic [FIELD_WIDTH-1:0] start_value;
   logic [FIELD_WIDTH-1:0] end_value;
   logic [FIELD_WIDTH-1:0] elem_bytes;
   logic [FIELD_WIDTH-1:0] query_offset;

   modport source (output valid, operation, entry_index, start_value, end_value,
                   elem_bytes, query_offset, input ready);
   modport sink   (input valid, operation, entry_index, start_value, end_value,
                   elem_bytes, query_offset, output ready);
endinterface

interface arof_rsp_if import arof_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] folded_offset;
   logic                   in_array;

   modport source (output valid, folded_offset, in_array, input ready);
   modport sink   (input valid, folded_offset, in_array, output ready);
endinterface

FILE: rtl/arof_table.sv
// ----------------------------------------------------------------------------
// arof_table
// Region table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module arof_table #(
   parameter int DEPTH = 8,
   parameter int DW    = 32,
   parameter int IW    = 3
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic [DW-1:0] wr_start,
   input  logic [DW-1:0] wr_end,
   input  logic [DW-1:0] wr_size,
   input  logic [IW-1:0] rd_addr,
   output logic [DW-1:0] rd_start,
   output logic [DW-1:0] rd_end,
   output logic [DW-1:0] rd_size
);

   logic [DW-1:0] start_mem [DEPTH];
   logic [DW-1:0] end_mem   [DEPTH];
   logic [DW-1:0] size_mem  [DEPTH];

   logic [DW-1:0] rd_start_ff;
   logic [DW-1:0] rd_end_ff;
   logic [DW-1:0] rd_size_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr] <= wr_start;
         end_mem[wr_addr]   <= wr_end;
         size_mem[wr_addr]  <= wr_size;
      end
      rd_start_ff <= start_mem[rd_addr];
      rd_end_ff   <= end_mem[rd_addr];
      rd_size_ff  <= size_mem[rd_addr];
   end

   assign rd_start = rd_start_ff;
   assign rd_end   = rd_end_ff;
   assign rd_size  = rd_size_ff;

endmodule

FILE: rtl/arof_rem_unit.sv
// ----------------------------------------------------------------------------
// arof_rem_unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module arof_rem_unit #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] remainder
);

   localparam int CNTW = $clog2(W + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    div_ff, div_in;
   logic [W:0]      trial;

   // A zero divisor always passes the trial and subtracts nothing, so the dividend shifts through unchanged.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = quo_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[W-1:0];
         end
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/array_region_offset_folder.sv
// ----------------------------------------------------------------------------
// array_region_offset_folder
// Region table with an offset folding walk over a shared remainder unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries loads (operation 0) and queries (operation 1). A load
//   writes one table slot in the cycle it is accepted and gives no response;
//   the next request can follow directly. A query walks the first
//   entries_in_use slots (set over the csr_ APB port, capped at MAX_ENTRIES),
//   stopping early at a slot whose start lies above the offset, and gives
//   one response on rsp_port with the folded offset and the hit flag. Each
//   slot visited passes through lookup and check; a slot that contains the
//   offset also runs the bit-serial remainder unit, and the walk ends in the
//   final state before the output register loads. req ready is low for the
//   whole walk.
//   The response sits in an output register; new requests are taken while it
//   waits. A walk that finishes while the previous response is still stalled
//   holds in its final state until rsp ready frees the register.
//   Reset clears entries_in_use and all control state; the table contents
//   stay undefined until loaded.
// ----------------------------------------------------------------------------
module array_region_offset_folder
   import arof_pkg::*;
#(
   parameter int MAX_ENTRIES  = 8,
   parameter int OFFSET_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   arof_req_if.sink              req_port,
   arof_rsp_if.source            rsp_port,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int DW = (OFFSET_WIDTH < FIELD_WIDTH) ? OFFSET_WIDTH : FIELD_WIDTH;
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   arof_state_type state_ff, state_in;

   logic [CFG_WIDTH-1:0] entries_ff, entries_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [DW-1:0]        ofs_ff, ofs_in;
   logic                 hit_ff, hit_in;
   logic [DW-1:0]        base_ff, base_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] rsp_fold_ff, rsp_fold_in;
   logic                   rsp_hit_ff, rsp_hit_in;

   logic          req_ready;
   logic          req_take;
   logic          csr_write;
   logic [CW-1:0] sat_count;
   logic          wr_en;
   logic          div_start;
   logic          div_done;
   logic [DW-1:0] div_rem;
   logic [DW-1:0] rd_start;
   logic [DW-1:0] rd_end;
   logic [DW-1:0] rd_size;
   logic [CW-1:0] idx_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_port.valid && req_ready;
   assign wr_en     = req_take && (req_port.operation == OP_LOAD) &&
                      (32'(req_port.entry_index) < 32'(MAX_ENTRIES));

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == CSR_ENTRIES_SLOT);
   assign csr_prdata = (csr_paddr[2] == CSR_ENTRIES_SLOT) ?
                       CSR_DATA_W'(entries_ff) : '0;

   assign entries_in = csr_write ? csr_pwdata[CFG_WIDTH-1:0] : entries_ff;
   assign sat_count  = (32'(entries_ff) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) :
                       CW'(entries_ff);
   assign idx_next   = idx_ff + CW'(1);

   arof_table #(
      .DEPTH (MAX_ENTRIES),
      .DW    (DW),
      .IW    (IW)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (IW'(req_port.entry_index)),
      .wr_start (req_port.start_value[DW-1:0]),
      .wr_end   (req_port.end_value[DW-1:0]),
      .wr_size  (req_port.elem_bytes[DW-1:0]),
      .rd_addr  (idx_ff[IW-1:0]),
      .rd_start (rd_start),
      .rd_end   (rd_end),
      .rd_size  (rd_size)
   );

   arof_rem_unit #(
      .W (DW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (ofs_ff - rd_start),
      .divisor   (rd_size),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ofs_in       = ofs_ff;
      hit_in       = hit_ff;
      base_in      = base_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_fold_in  = rsp_fold_ff;
      rsp_hit_in   = rsp_hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_port.operation == OP_QUERY)) begin
               count_in = sat_count;
               idx_in   = '0;
               ofs_in   = req_port.query_offset[DW-1:0];
               hit_in   = 1'b0;
               state_in = (sat_count == '0) ? ST_FINISH : ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (rd_start > ofs_ff) begin
               state_in = ST_FINISH;
            end else if (ofs_ff < rd_end) begin
               hit_in    = 1'b1;
               base_in   = rd_start;
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               idx_in   = idx_next;
               state_in = (idx_next == count_ff) ? ST_FINISH : ST_LOOKUP;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               // the remainder never exceeds offset - start, so no wrap here
               ofs_in   = base_ff + div_rem;
               idx_in   = idx_next;
               state_in = (idx_next == count_ff) ? ST_FINISH : ST_LOOKUP;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_fold_in  = FIELD_WIDTH'(ofs_ff);
               rsp_hit_in   = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
      end
      ofs_ff      <= ofs_in;
      hit_ff      <= hit_in;
      base_ff     <= base_in;
      rsp_fold_ff <= rsp_fold_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   assign req_port.ready         = req_ready;
   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.folded_offset = rsp_fold_ff;
   assign rsp_port.in_array      = rsp_hit_ff;

endmodule

FILE: rtl/arof_checker.sv
// ----------------------------------------------------------------------------
// arof_checker
// Port-level checks of the region folder, bound to the top level.
// ----------------------------------------------------------------------------
`include "array_region_offset_folder_macros.svh"

module arof_checker
   import arof_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_operation,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [FIELD_WIDTH-1:0] rsp_folded_offset,
   input logic                   rsp_in_array
);

   `AROF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_folded_offset) && $stable(rsp_in_array), "stalled response changed")
   `AROF_ASSERT(a_query_busy, clock, reset, req_valid && req_ready && (req_operation == OP_QUERY) |=> !req_ready, "ready during query walk")
   `AROF_ASSERT(a_load_quiet, clock, reset, req_valid && req_ready && (req_operation == OP_LOAD) && !rsp_valid |=> req_ready && !rsp_valid, "load produced response or stall")
   `AROF_ASSERT(a_rsp_from_walk, clock, reset, $rose(rsp_valid) |-> !$past(req_ready), "response without a walk")
   `AROF_ASSERT_RST(a_reset_clear, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind array_region_offset_folder arof_checker u_arof_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_port.valid),
   .req_ready         (req_port.ready),
   .req_operation     (req_port.operation),
   .rsp_valid         (rsp_port.valid),
   .rsp_ready         (rsp_port.ready),
   .rsp_folded_offset (rsp_port.folded_offset),
   .rsp_in_array      (rsp_port.in_array)
);
